@@ rtl/qvr_pkg.sv @@
`default_nettype none

package qvr_pkg;

  localparam int QUAT_W  = 16;
  localparam int VEC_W   = 32;
  localparam int RES_W   = 32;

  // Products of two quaternion parts, then the norm and matrix terms.
  localparam int PRD_W   = 2 * QUAT_W;
  localparam int N_W     = PRD_W + 1;
  localparam int M_W     = PRD_W + 1;
  // Matrix term times vector part, and the row sum with doubled off-diagonals.
  localparam int P_W     = M_W + VEC_W;
  localparam int ACC_W   = P_W + 2;
  localparam int MAG_W   = ACC_W - 1;

  // Divider: remainder stays below the norm; quotient bits below the overflow point.
  localparam int REM_W   = N_W - 1;
  localparam int QUO_W   = MAG_W - REM_W;
  localparam int QR_W    = QUO_W + 1;

  localparam int FE_LAT  = 5;
  localparam int DIV_LAT = QUO_W + 2;
  localparam int TOT_LAT = FE_LAT + DIV_LAT;

  localparam logic [RES_W-1:0] RES_POS_LIM = {1'b0, {(RES_W-1){1'b1}}};
  localparam logic [RES_W-1:0] RES_NEG_LIM = {1'b1, {(RES_W-1){1'b0}}};

  typedef struct packed {
    logic signed [QUAT_W-1:0] quat_w;
    logic signed [QUAT_W-1:0] quat_x;
    logic signed [QUAT_W-1:0] quat_y;
    logic signed [QUAT_W-1:0] quat_z;
    logic signed [VEC_W-1:0]  vec_x;
    logic signed [VEC_W-1:0]  vec_y;
    logic signed [VEC_W-1:0]  vec_z;
  } qvr_in_t;

  typedef struct packed {
    logic signed [RES_W-1:0] rot_x;
    logic signed [RES_W-1:0] rot_y;
    logic signed [RES_W-1:0] rot_z;
    logic                    zero_norm;
    logic                    saturated;
  } qvr_out_t;

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
    logic [N_W-1:0]   den;
  } qvr_dreq_t;

  typedef struct packed {
    logic             sat;
    logic [RES_W-1:0] val;
  } qvr_dres_t;

endpackage

`default_nettype wire

@@ rtl/qvr_div.sv @@
`default_nettype none

module qvr_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  qvr_pkg::qvr_dreq_t in_req,
  output logic               out_vld,
  output qvr_pkg::qvr_dres_t out_res
);
  import qvr_pkg::*;

  typedef struct packed {
    logic             neg;
    logic             ovf;
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] lo;
    logic [QUO_W-1:0] quo;
    logic [N_W-1:0]   den;
  } stg_t;

  // One restoring step: bring down the next dividend bit, subtract if it fits.
  function automatic stg_t div_step(stg_t s);
    stg_t           o;
    logic [N_W-1:0] t;
    logic [N_W-1:0] d;
    o    = s;
    t    = {s.rem, s.lo[QUO_W-1]};
    d    = t - s.den;
    o.lo = {s.lo[QUO_W-2:0], 1'b0};
    if (t >= s.den) begin
      o.rem = d[REM_W-1:0];
      o.quo = {s.quo[QUO_W-2:0], 1'b1};
    end else begin
      o.rem = t[REM_W-1:0];
      o.quo = {s.quo[QUO_W-2:0], 1'b0};
    end
    return o;
  endfunction

  stg_t             ent;
  stg_t             stg_r   [QUO_W];
  stg_t             stg_nxt [QUO_W];
  logic [QUO_W-1:0] vld_r;

  logic             hlf_vld_r;
  logic             hlf_neg_r;
  logic             hlf_ovf_r;
  logic             hlf_bit_r;
  logic [QUO_W-1:0] hlf_quo_r;
  logic             hlf_bit_nxt;

  logic [QR_W-1:0]  rnd;
  logic [QR_W-1:0]  lim;
  qvr_dres_t        res_nxt;
  qvr_dres_t        res_r;
  logic             out_vld_r;

  // Top bits at or above the norm mean the quotient has no room: flag and saturate.
  always_comb begin
    ent.neg = in_req.neg;
    ent.ovf = {1'b0, in_req.mag[MAG_W-1:QUO_W]} >= in_req.den;
    ent.rem = in_req.mag[MAG_W-1:QUO_W];
    ent.lo  = in_req.mag[QUO_W-1:0];
    ent.quo = '0;
    ent.den = in_req.den;
  end

  always_comb begin
    stg_nxt[0] = div_step(ent);
    for (int i = 1; i < QUO_W; i++) begin
      stg_nxt[i] = div_step(stg_r[i-1]);
    end
  end

  always_ff @(posedge clk) begin
    stg_r <= stg_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[QUO_W-2:0], in_vld};
    end
  end

  // Next quotient bit below the point decides round half away from zero.
  assign hlf_bit_nxt = {stg_r[QUO_W-1].rem, 1'b0} >= stg_r[QUO_W-1].den;

  always_ff @(posedge clk) begin
    hlf_neg_r <= stg_r[QUO_W-1].neg;
    hlf_ovf_r <= stg_r[QUO_W-1].ovf;
    hlf_quo_r <= stg_r[QUO_W-1].quo;
    hlf_bit_r <= hlf_bit_nxt;
  end

  always_comb begin
    rnd = {1'b0, hlf_quo_r} + QR_W'(hlf_bit_r);
    lim = hlf_neg_r ? QR_W'(RES_NEG_LIM) : QR_W'(RES_POS_LIM);
    if (hlf_ovf_r || (rnd > lim)) begin
      res_nxt.sat = 1'b1;
      res_nxt.val = hlf_neg_r ? RES_NEG_LIM : RES_POS_LIM;
    end else begin
      res_nxt.sat = 1'b0;
      res_nxt.val = hlf_neg_r ? (RES_W'(0) - rnd[RES_W-1:0]) : rnd[RES_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hlf_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      hlf_vld_r <= vld_r[QUO_W-1];
      out_vld_r <= hlf_vld_r;
    end
  end

  assign out_vld = out_vld_r;
  assign out_res = res_r;

endmodule

`default_nettype wire

@@ rtl/quaternion_vector_rotation.sv @@
`default_nettype none

// Rotates a Q16.16 vector by a Q2.14 quaternion of any nonzero length, giving
// q * (0, v) * conj(q) / |q|^2 rounded to nearest (ties away from zero) and
// clipped to the 32-bit range. A word is taken on every clock edge with start
// high; busy is never raised. Each result appears for a single cycle with
// out_strobe, in order, one per clock at full rate: five stages form the
// products, the scaled rotation matrix, the row sums and the sign and
// magnitude, then a division pipeline yields one quotient bit per stage
// (34 stages), followed by a rounding stage and a saturation stage. The
// receiver cannot hold results off. An all-zero quaternion returns a zero
// vector with zero_norm set.
module quaternion_vector_rotation (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  qvr_pkg::qvr_in_t  in_item,
  output logic              busy,
  output logic              out_strobe,
  output qvr_pkg::qvr_out_t out_item
);
  import qvr_pkg::*;

  // Stage 1: pairwise products of the quaternion parts
  logic                    vld1_r;
  logic signed [PRD_W-1:0] ww_r, xx_r, yy_r, zz_r;
  logic signed [PRD_W-1:0] xy_r, wz_r, xz_r, wy_r, yz_r, wx_r;
  logic signed [VEC_W-1:0] vec1_r [3];

  // Stage 2: norm and matrix; off-diagonal terms held at half value
  logic                    vld2_r;
  logic [N_W-1:0]          n2_r;
  logic                    zero2_r;
  logic signed [M_W-1:0]   mtx2_r [3][3];
  logic signed [VEC_W-1:0] vec2_r [3];

  // Stage 3: matrix times vector
  logic                    vld3_r;
  logic [N_W-1:0]          n3_r;
  logic                    zero3_r;
  logic signed [P_W-1:0]   prd3_r [3][3];

  // Stage 4: row sums
  logic                    vld4_r;
  logic [N_W-1:0]          n4_r;
  logic                    zero4_r;
  logic signed [ACC_W-1:0] acc4_nxt [3];
  logic signed [ACC_W-1:0] acc4_r   [3];

  // Stage 5: sign and magnitude
  logic                    vld5_r;
  logic [N_W-1:0]          n5_r;
  logic                    zero5_r;
  logic                    neg5_r [3];
  logic [MAG_W-1:0]        mag5_r [3];

  logic [DIV_LAT-1:0]      zln_r;

  qvr_dreq_t               dreq [3];
  qvr_dres_t               dres [3];
  logic [2:0]              dvld;
  logic                    zero_out;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
      vld5_r <= 1'b0;
    end else begin
      vld1_r <= start && !busy;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      vld4_r <= vld3_r;
      vld5_r <= vld4_r;
    end
  end

  always_ff @(posedge clk) begin
    ww_r      <= in_item.quat_w * in_item.quat_w;
    xx_r      <= in_item.quat_x * in_item.quat_x;
    yy_r      <= in_item.quat_y * in_item.quat_y;
    zz_r      <= in_item.quat_z * in_item.quat_z;
    xy_r      <= in_item.quat_x * in_item.quat_y;
    wz_r      <= in_item.quat_w * in_item.quat_z;
    xz_r      <= in_item.quat_x * in_item.quat_z;
    wy_r      <= in_item.quat_w * in_item.quat_y;
    yz_r      <= in_item.quat_y * in_item.quat_z;
    wx_r      <= in_item.quat_w * in_item.quat_x;
    vec1_r[0] <= in_item.vec_x;
    vec1_r[1] <= in_item.vec_y;
    vec1_r[2] <= in_item.vec_z;
  end

  // Squares are never negative, so their low bits add as unsigned.
  always_ff @(posedge clk) begin
    n2_r <= N_W'(ww_r[PRD_W-2:0]) + N_W'(xx_r[PRD_W-2:0]) +
            N_W'(yy_r[PRD_W-2:0]) + N_W'(zz_r[PRD_W-2:0]);
    zero2_r <= (ww_r == '0) && (xx_r == '0) && (yy_r == '0) && (zz_r == '0);
    mtx2_r[0][0] <= M_W'(ww_r) + M_W'(xx_r) - M_W'(yy_r) - M_W'(zz_r);
    mtx2_r[0][1] <= M_W'(xy_r) - M_W'(wz_r);
    mtx2_r[0][2] <= M_W'(xz_r) + M_W'(wy_r);
    mtx2_r[1][0] <= M_W'(xy_r) + M_W'(wz_r);
    mtx2_r[1][1] <= M_W'(ww_r) - M_W'(xx_r) + M_W'(yy_r) - M_W'(zz_r);
    mtx2_r[1][2] <= M_W'(yz_r) - M_W'(wx_r);
    mtx2_r[2][0] <= M_W'(xz_r) - M_W'(wy_r);
    mtx2_r[2][1] <= M_W'(yz_r) + M_W'(wx_r);
    mtx2_r[2][2] <= M_W'(ww_r) - M_W'(xx_r) - M_W'(yy_r) + M_W'(zz_r);
    vec2_r <= vec1_r;
  end

  always_ff @(posedge clk) begin
    n3_r    <= n2_r;
    zero3_r <= zero2_r;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prd3_r[i][j] <= mtx2_r[i][j] * vec2_r[j];
      end
    end
  end

  // Double the off-diagonal products back to full weight.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc4_nxt[i] = '0;
      for (int j = 0; j < 3; j++) begin
        acc4_nxt[i] = acc4_nxt[i] +
                      ((j == i) ? ACC_W'(prd3_r[i][j]) : (ACC_W'(prd3_r[i][j]) <<< 1));
      end
    end
  end

  always_ff @(posedge clk) begin
    n4_r    <= n3_r;
    zero4_r <= zero3_r;
    acc4_r  <= acc4_nxt;
  end

  always_ff @(posedge clk) begin
    n5_r    <= n4_r;
    zero5_r <= zero4_r;
    for (int i = 0; i < 3; i++) begin
      neg5_r[i] <= acc4_r[i][ACC_W-1];
      mag5_r[i] <= acc4_r[i][ACC_W-1] ? MAG_W'(-acc4_r[i]) : MAG_W'(acc4_r[i]);
    end
  end

  // Carry the zero-norm mark alongside the divider.
  always_ff @(posedge clk) begin
    zln_r <= {zln_r[DIV_LAT-2:0], zero5_r};
  end

  for (genvar g = 0; g < 3; g++) begin : g_div
    assign dreq[g].neg = neg5_r[g];
    assign dreq[g].mag = mag5_r[g];
    assign dreq[g].den = n5_r;

    qvr_div u_div (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (vld5_r),
      .in_req  (dreq[g]),
      .out_vld (dvld[g]),
      .out_res (dres[g])
    );
  end

  assign zero_out   = zln_r[DIV_LAT-1];
  assign out_strobe = dvld[0];

  always_comb begin
    if (zero_out) begin
      out_item.rot_x     = '0;
      out_item.rot_y     = '0;
      out_item.rot_z     = '0;
      out_item.zero_norm = 1'b1;
      out_item.saturated = 1'b0;
    end else begin
      out_item.rot_x     = dres[0].val;
      out_item.rot_y     = dres[1].val;
      out_item.rot_z     = dres[2].val;
      out_item.zero_norm = 1'b0;
      out_item.saturated = dres[0].sat | dres[1].sat | dres[2].sat;
    end
  end

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start, TOT_LAT))
    else $error("result word without a start word at the pipeline latency");

  a_lanes: assert property (@(posedge clk) disable iff (!rst_n)
    (dvld[1] == dvld[0]) && (dvld[2] == dvld[0]))
    else $error("divider lanes out of step");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.zero_norm) |->
      (($past(in_item.quat_w, TOT_LAT) == '0) && ($past(in_item.quat_x, TOT_LAT) == '0) &&
       ($past(in_item.quat_y, TOT_LAT) == '0) && ($past(in_item.quat_z, TOT_LAT) == '0)))
    else $error("zero norm flagged for a nonzero quaternion");

  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.saturated) |->
      ((out_item.rot_x == RES_POS_LIM) || (out_item.rot_x == RES_NEG_LIM) ||
       (out_item.rot_y == RES_POS_LIM) || (out_item.rot_y == RES_NEG_LIM) ||
       (out_item.rot_z == RES_POS_LIM) || (out_item.rot_z == RES_NEG_LIM)))
    else $error("saturation flagged with no component at a limit");

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
`default_nettype none

module testbench;
  import qvr_pkg::*;

  localparam int RANDOM_WORDS = 1550;
  localparam int IDLE_PCT     = 31;
  // no idling on the sender side for this stretch of words
  localparam int CALM_FROM    = 400;
  localparam int CALM_TO      = 700;
  localparam int MID_DRAIN    = 900;
  // longest honest quiet spell is the pipeline depth plus a short idle run
  localparam int QUIET_LIMIT  = 2000;

  localparam logic signed [QUAT_W-1:0] QMAX = 16'sh7FFF;
  localparam logic signed [QUAT_W-1:0] QMIN = 16'sh8000;
  localparam logic signed [VEC_W-1:0]  VMAX = 32'sh7FFF_FFFF;
  localparam logic signed [VEC_W-1:0]  VMIN = 32'sh8000_0000;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  logic     out_strobe;
  qvr_in_t  in_item;
  qvr_out_t out_item;

  qvr_in_t  pending_words[$];
  qvr_out_t expected_rot[$];
  int       words_sent;
  int       directed_n;
  int       mismatches;
  int       quiet_cycles;
  logic     word_taken;

  quaternion_vector_rotation DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_item    (in_item),
    .busy       (busy),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  always #1 clk = ~clk;

  // Rounded (ties away from zero), clipped num / norm; top bit flags a clip.
  function automatic logic [RES_W:0] scale_row(logic signed [127:0] num,
                                               logic [127:0] norm);
    logic             neg;
    logic [127:0]     mag;
    logic [127:0]     quo;
    logic [127:0]     rem;
    logic [127:0]     lim;
    logic [RES_W-1:0] quo_lo;
    neg = num[127];
    mag = neg ? -num : num;
    quo = mag / norm;
    rem = mag % norm;
    if (2 * rem >= norm) quo = quo + 1;
    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (quo > lim) return {1'b1, neg ? RES_NEG_LIM : RES_POS_LIM};
    quo_lo = quo[RES_W-1:0];
    return {1'b0, neg ? -quo_lo : quo_lo};
  endfunction

  // q * (0, v) * q^-1 taken as (M v) / |q|^2 with exact integer products.
  function automatic qvr_out_t rotate_vector(qvr_in_t wd);
    logic signed [127:0] w, x, y, z, norm;
    logic signed [127:0] mat [3][3];
    logic signed [127:0] vec [3];
    logic signed [127:0] acc;
    logic [RES_W:0]      row [3];
    qvr_out_t            r;
    w = wd.quat_w;
    x = wd.quat_x;
    y = wd.quat_y;
    z = wd.quat_z;
    vec[0] = wd.vec_x;
    vec[1] = wd.vec_y;
    vec[2] = wd.vec_z;
    r = '0;
    norm = w * w + x * x + y * y + z * z;
    if (norm == 0) begin
      r.zero_norm = 1'b1;
      return r;
    end
    mat[0][0] = w * w + x * x - y * y - z * z;
    mat[0][1] = 2 * (x * y - w * z);
    mat[0][2] = 2 * (x * z + w * y);
    mat[1][0] = 2 * (x * y + w * z);
    mat[1][1] = w * w - x * x + y * y - z * z;
    mat[1][2] = 2 * (y * z - w * x);
    mat[2][0] = 2 * (x * z - w * y);
    mat[2][1] = 2 * (y * z + w * x);
    mat[2][2] = w * w - x * x - y * y + z * z;
    for (int i = 0; i < 3; i++) begin
      acc = mat[i][0] * vec[0] + mat[i][1] * vec[1] + mat[i][2] * vec[2];
      row[i] = scale_row(acc, norm);
    end
    r.rot_x     = row[0][RES_W-1:0];
    r.rot_y     = row[1][RES_W-1:0];
    r.rot_z     = row[2][RES_W-1:0];
    r.saturated = row[0][RES_W] | row[1][RES_W] | row[2][RES_W];
    return r;
  endfunction

  function automatic qvr_in_t make_word(
    input logic signed [QUAT_W-1:0] qw, qx, qy, qz,
    input logic signed [VEC_W-1:0]  vx, vy, vz
  );
    qvr_in_t wd;
    wd.quat_w = qw;
    wd.quat_x = qx;
    wd.quat_y = qy;
    wd.quat_z = qz;
    wd.vec_x  = vx;
    wd.vec_y  = vy;
    wd.vec_z  = vz;
    return wd;
  endfunction

  function automatic logic [QUAT_W-1:0] small_part();
    return QUAT_W'($urandom_range(0, 8) - 4);
  endfunction

  function automatic logic [QUAT_W-1:0] extreme_part();
    case ($urandom_range(0, 4))
      0:       return QMAX;
      1:       return QMIN;
      2:       return '0;
      3:       return 16'sd1;
      default: return -16'sd1;
    endcase
  endfunction

  function automatic logic [VEC_W-1:0] vec_part(int kind, logic neg);
    case (kind)
      0:       return neg ? (32'h8000_0000 | ($urandom & 32'h00FF_FFFF))
                          : (32'h7F00_0000 | ($urandom & 32'h00FF_FFFF));
      1:       return VEC_W'($urandom_range(0, 2000) - 1000);
      default: return $urandom;
    endcase
  endfunction

  task automatic load_directed();
    // identity rotations, unit and smallest nonzero norm, and w at its most negative
    pending_words.push_back(make_word(16384, 0, 0, 0, 32'sh1_0000, 32'sh2_0000, -32'sh3_0000));
    pending_words.push_back(make_word(1, 0, 0, 0, VMAX, VMIN, 12345));
    pending_words.push_back(make_word(QMIN, 0, 0, 0, VMIN, VMIN, VMIN));
    // zero quaternion
    pending_words.push_back(make_word(0, 0, 0, 0, VMAX, VMIN, VMAX));
    pending_words.push_back(make_word(0, 0, 0, 0, 1, 2, 3));
    // largest norm, and the other corners
    pending_words.push_back(make_word(QMIN, QMIN, QMIN, QMIN, VMAX, VMAX, VMAX));
    pending_words.push_back(make_word(QMAX, QMAX, QMAX, QMAX, VMAX, VMIN, 0));
    pending_words.push_back(make_word(QMAX, QMIN, QMAX, QMIN, VMIN, VMAX, VMIN));
    pending_words.push_back(make_word(0, QMIN, QMAX, 0, VMIN, VMAX, VMIN));
    pending_words.push_back(make_word(0, QMAX, 0, 0, VMAX, VMAX, VMAX));
    // 45 degrees about z lifts a diagonal vector past the range
    pending_words.push_back(make_word(15137, 0, 0, 6270, VMAX, VMAX, 0));
    pending_words.push_back(make_word(15137, 0, 0, 6270, VMIN, VMIN, 0));
    pending_words.push_back(make_word(15137, 0, 0, -6270, VMAX, VMIN, VMIN));
    // half turns negate the most negative value: clip by one
    pending_words.push_back(make_word(0, 0, 0, 1, VMIN, VMIN, VMIN));
    pending_words.push_back(make_word(0, 1, 0, 0, VMAX, VMIN, VMIN));
    pending_words.push_back(make_word(0, 0, 0, 1, VMAX, VMAX, 0));
    // small norms leave fractions to round
    pending_words.push_back(make_word(1, 1, 1, 0, 1, 1, 1));
    pending_words.push_back(make_word(1, 1, 1, 0, -1, -2, -3));
    pending_words.push_back(make_word(2, 1, 0, 0, 1, -1, 2));
    pending_words.push_back(make_word(1, 2, 3, 4, 7, -7, 100));
    pending_words.push_back(make_word(-3, 2, -1, 1, -5, 11, -13));
  endtask

  task automatic load_random();
    qvr_in_t wd;
    int      qsel;
    int      vkind;
    logic    vneg;
    for (int k = 0; k < RANDOM_WORDS; k++) begin
      qsel = $urandom_range(0, 19);
      if (qsel <= 10) begin
        wd.quat_w = QUAT_W'($urandom);
        wd.quat_x = QUAT_W'($urandom);
        wd.quat_y = QUAT_W'($urandom);
        wd.quat_z = QUAT_W'($urandom);
      end else if (qsel <= 14) begin
        wd.quat_w = small_part();
        wd.quat_x = small_part();
        wd.quat_y = small_part();
        wd.quat_z = small_part();
      end else if (qsel <= 17) begin
        wd.quat_w = '0;
        wd.quat_x = '0;
        wd.quat_y = '0;
        wd.quat_z = '0;
        case ($urandom_range(0, 3))
          0:       wd.quat_w = QUAT_W'($urandom);
          1:       wd.quat_x = QUAT_W'($urandom);
          2:       wd.quat_y = QUAT_W'($urandom);
          default: wd.quat_z = QUAT_W'($urandom);
        endcase
      end else if (qsel == 18) begin
        wd.quat_w = '0;
        wd.quat_x = '0;
        wd.quat_y = '0;
        wd.quat_z = '0;
      end else begin
        wd.quat_w = extreme_part();
        wd.quat_x = extreme_part();
        wd.quat_y = extreme_part();
        wd.quat_z = extreme_part();
      end
      vkind = $urandom_range(0, 9);
      vkind = (vkind <= 5) ? 2 : (vkind <= 7) ? 0 : 1;
      vneg  = 1'($urandom_range(0, 1));
      wd.vec_x = vec_part(vkind, vneg);
      wd.vec_y = vec_part(vkind, vneg);
      wd.vec_z = vec_part(vkind, vneg);
      pending_words.push_back(wd);
    end
  endtask

  task automatic check_field(string name, logic [RES_W-1:0] want, logic [RES_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Sender: advance on a taken word, idle at random, hold off for drains.
  always @(negedge clk) begin : drive_words
    logic hold_off;
    logic idle;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || word_taken) begin
      hold_off = (words_sent == directed_n || words_sent == MID_DRAIN) &&
                 expected_rot.size() != 0;
      idle = (words_sent < CALM_FROM || words_sent >= CALM_TO) &&
             $urandom_range(0, 99) < IDLE_PCT;
      if (pending_words.size() == 0 || hold_off || idle) begin
        start   <= 1'b0;
        in_item <= qvr_in_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
      end else begin
        start      <= 1'b1;
        in_item    <= pending_words.pop_front();
        words_sent <= words_sent + 1;
      end
    end
  end

  // Take words, check results, and watch for a stall.
  always @(posedge clk) begin : watch_ports
    qvr_out_t want;
    logic     took;
    took = rst_n && start && !busy;
    word_taken <= took;
    if (rst_n && out_strobe) begin
      if (expected_rot.size() == 0) begin
        $display("%0t: result with no word outstanding, actual %h", $time, out_item);
        mismatches++;
      end else begin
        want = expected_rot.pop_front();
        check_field("rot_x", want.rot_x, out_item.rot_x);
        check_field("rot_y", want.rot_y, out_item.rot_y);
        check_field("rot_z", want.rot_z, out_item.rot_z);
        check_field("zero_norm", RES_W'(want.zero_norm), RES_W'(out_item.zero_norm));
        check_field("saturated", RES_W'(want.saturated), RES_W'(out_item.saturated));
      end
    end
    if (took) expected_rot.push_back(rotate_vector(in_item));
    if (!rst_n || took || out_strobe) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_item      = '0;
    word_taken   = 1'b0;
    words_sent   = 0;
    mismatches   = 0;
    quiet_cycles = 0;
    load_directed();
    directed_n = pending_words.size();
    load_random();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    while (pending_words.size() != 0 || start) @(posedge clk);
    while (expected_rot.size() != 0) @(posedge clk);
    repeat (TOT_LAT + 10) @(posedge clk);
    if (mismatches == 0 && expected_rot.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/qvr_pkg.sv
rtl/qvr_div.sv
rtl/quaternion_vector_rotation.sv
sim/testbench.sv
